// ===== rtl/compacting_key_value_table_unit_defines.svh =====
// Assertion macros for the compacting key/value table unit.
`ifndef COMPACTING_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KVT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kvt assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KVT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kvt assertion failed");

`endif

// ===== rtl/kvt_pkg.sv =====
// Shared constants, codes and types of the compacting key/value table.
package kvt_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_UPDATED  = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_NOOP     = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_UPDATE,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_W-1:0]       pos;
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
        logic [CNT_W-1:0]       count;
    } t_cell_ctl;

endpackage

// ===== rtl/kvt_cell.sv =====
// One table slot: holds a key/value pair, compares, updates and shifts down.
module kvt_cell (
    input  logic                             i_clk,
    input  logic [kvt_pkg::IDX_W-1:0]        i_index,
    input  kvt_pkg::t_cell_ctl               i_ctl,
    input  logic [kvt_pkg::KEY_BITS-1:0]     i_next_key,
    input  logic [kvt_pkg::VALUE_BITS-1:0]   i_next_value,
    output logic [kvt_pkg::KEY_BITS-1:0]     o_key,
    output logic [kvt_pkg::VALUE_BITS-1:0]   o_value,
    output logic                             o_match
);

    logic [kvt_pkg::KEY_BITS-1:0]   r_key;
    logic [kvt_pkg::VALUE_BITS-1:0] r_value;
    logic [kvt_pkg::KEY_BITS-1:0]   n_key;
    logic [kvt_pkg::VALUE_BITS-1:0] n_value;
    logic                           w_live;

    assign w_live  = {1'b0, i_index} < kvt_pkg::CNT_W'(i_ctl.count);
    assign o_match = w_live && (r_key == i_ctl.key);
    assign o_key   = r_key;
    assign o_value = r_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        case (i_ctl.op)
            kvt_pkg::CELL_SHIFT: begin
                if (i_index >= i_ctl.pos) begin
                    n_key   = i_next_key;
                    n_value = i_next_value;
                end
            end
            kvt_pkg::CELL_UPDATE: begin
                if (i_index == i_ctl.pos) begin
                    n_value = i_ctl.value;
                end
            end
            kvt_pkg::CELL_INSERT: begin
                if (i_index == i_ctl.pos) begin
                    n_key   = i_ctl.key;
                    n_value = i_ctl.value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

// ===== rtl/compacting_key_value_table_unit.sv =====
// Top level: a chain of table cells with a compare cycle and an update cycle.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | to unit   | i_valid / o_ready  | i_opcode, i_lookup_key, i_write_value
//  out     | from unit | o_valid / i_ready  | o_read_value, o_status, o_entry_count
//
// Each beat passes through the accepting cycle, a compare cycle in which every cell matches
// the key in parallel, and an update cycle that writes one cell or shifts the cells above
// the removed slot down by one.
// A result sits in an output register; the update cycle holds while it is not taken.
// Synchronous active-low reset empties the table (count zero); no clearing pass.
`include "compacting_key_value_table_unit_defines.svh"

module compacting_key_value_table_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [0:0]   i_opcode,
    input  logic [63:0]  i_lookup_key,
    input  logic [63:0]  i_write_value,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [63:0]  o_read_value,
    output logic [2:0]   o_status,
    output logic [6:0]   o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                              r_state;
    t_state                              n_state;
    logic                                r_op;
    logic [kvt_pkg::KEY_BITS-1:0]        r_key;
    logic [kvt_pkg::VALUE_BITS-1:0]      r_val;
    logic [kvt_pkg::CNT_W-1:0]           r_count;
    logic [kvt_pkg::CNT_W-1:0]           n_count;
    logic [kvt_pkg::MAX_ENTRIES-1:0]     r_match;
    logic                                r_out_valid;
    logic [63:0]                         r_out_rd;
    logic [2:0]                          r_out_status;
    logic [6:0]                          r_out_cnt;

    logic [kvt_pkg::MAX_ENTRIES-1:0]     w_match;
    logic [kvt_pkg::KEY_BITS-1:0]        w_cell_key   [kvt_pkg::MAX_ENTRIES];
    logic [kvt_pkg::VALUE_BITS-1:0]      w_cell_value [kvt_pkg::MAX_ENTRIES];
    kvt_pkg::t_cell_ctl                  w_ctl;
    logic                                w_load;
    logic                                w_hit;
    logic                                w_val_zero;
    logic                                w_full;
    logic [kvt_pkg::IDX_W-1:0]           w_pos;
    logic [kvt_pkg::VALUE_BITS-1:0]      w_rd;
    logic [2:0]                          n_status;
    kvt_pkg::t_cell_op                   n_cell_op;

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_rd;
    assign o_status      = r_out_status;
    assign o_entry_count = r_out_cnt;

    assign w_load     = (r_state == S_UPD) && (!r_out_valid || i_ready);
    assign w_hit      = |r_match;
    assign w_val_zero = (r_val == '0);
    assign w_full     = (r_count >= kvt_pkg::CNT_W'(kvt_pkg::MAX_ENTRIES));

    // Encode the single matching slot and gather its value.
    always_comb begin
        w_pos = '0;
        w_rd  = '0;
        for (int i = 0; i < kvt_pkg::MAX_ENTRIES; i++) begin
            if (r_match[i]) begin
                w_pos = w_pos | kvt_pkg::IDX_W'(i);
                w_rd  = w_rd | w_cell_value[i];
            end
        end
    end

    always_comb begin
        n_status  = kvt_pkg::ST_MISS;
        n_cell_op = kvt_pkg::CELL_HOLD;
        n_count   = r_count;
        if (r_op == kvt_pkg::OP_GET) begin
            n_status = w_hit ? kvt_pkg::ST_HIT : kvt_pkg::ST_MISS;
        end else if (w_hit) begin
            if (w_val_zero) begin
                n_status  = kvt_pkg::ST_REMOVED;
                n_cell_op = kvt_pkg::CELL_SHIFT;
                n_count   = r_count - kvt_pkg::CNT_W'(1);
            end else begin
                n_status  = kvt_pkg::ST_UPDATED;
                n_cell_op = kvt_pkg::CELL_UPDATE;
            end
        end else if (w_val_zero) begin
            n_status = kvt_pkg::ST_NOOP;
        end else if (w_full) begin
            n_status = kvt_pkg::ST_FULL;
        end else begin
            n_status  = kvt_pkg::ST_INSERTED;
            n_cell_op = kvt_pkg::CELL_INSERT;
            n_count   = r_count + kvt_pkg::CNT_W'(1);
        end
    end

    always_comb begin
        w_ctl.op    = w_load ? n_cell_op : kvt_pkg::CELL_HOLD;
        w_ctl.pos   = (n_cell_op == kvt_pkg::CELL_INSERT) ?
                      r_count[kvt_pkg::IDX_W-1:0] : w_pos;
        w_ctl.key   = r_key;
        w_ctl.value = r_val;
        w_ctl.count = r_count;
    end

    for (genvar g = 0; g < kvt_pkg::MAX_ENTRIES; g++) begin : g_cell
        if (g == kvt_pkg::MAX_ENTRIES - 1) begin : g_last
            kvt_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (kvt_pkg::IDX_W'(g)),
                .i_ctl        (w_ctl),
                .i_next_key   (w_cell_key[g]),
                .i_next_value (w_cell_value[g]),
                .o_key        (w_cell_key[g]),
                .o_value      (w_cell_value[g]),
                .o_match      (w_match[g])
            );
        end else begin : g_mid
            kvt_cell u_cell (
                .i_clk        (i_clk),
                .i_index      (kvt_pkg::IDX_W'(g)),
                .i_ctl        (w_ctl),
                .i_next_key   (w_cell_key[g+1]),
                .i_next_value (w_cell_value[g+1]),
                .o_key        (w_cell_key[g]),
                .o_value      (w_cell_value[g]),
                .o_match      (w_match[g])
            );
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op  <= i_opcode[0];
            r_key <= i_lookup_key[kvt_pkg::KEY_BITS-1:0];
            r_val <= i_write_value[kvt_pkg::VALUE_BITS-1:0];
        end
        if (r_state == S_CMP) begin
            r_match <= w_match;
        end
        if (w_load) begin
            r_out_rd     <= (r_op == kvt_pkg::OP_GET) ? 64'(w_rd) : 64'd0;
            r_out_status <= n_status;
            r_out_cnt    <= 7'(n_count);
        end
    end

    `KVT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= kvt_pkg::CNT_W'(kvt_pkg::MAX_ENTRIES))
    `KVT_ASSERT_NOW(a_single_match, r_state == S_UPD, $onehot0(r_match))
    `KVT_ASSERT_NEXT(a_remove_dec, w_load && n_status == kvt_pkg::ST_REMOVED,
                     r_count == $past(r_count) - kvt_pkg::CNT_W'(1))
    `KVT_ASSERT_NOW(a_result_src, $rose(o_valid), $past(r_state) == S_UPD)

endmodule

// ===== tb/compacting_key_value_table_unit_tb.sv =====
// Testbench for the compacting key/value table: directed table, phased random traffic, scoreboard.
module compacting_key_value_table_unit_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE   = 96;
    localparam int NUM_ROWS    = 21;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MSB  = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0] rd;
        logic [2:0]  status;
        logic [6:0]  count;
    } t_kv_result;

    typedef struct packed {
        logic        op;
        logic [63:0] key;
        logic [63:0] val;
        logic        checked;
        t_kv_result  want;
    } t_kv_row;

    typedef enum int {
        PH_GROW,
        PH_MIX,
        PH_SHRINK
    } t_traffic_phase;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [0:0]  i_opcode      = kvt_pkg::OP_GET;
    logic [63:0] i_lookup_key  = '0;
    logic [63:0] i_write_value = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [63:0] o_read_value;
    logic [2:0]  o_status;
    logic [6:0]  o_entry_count;

    logic [63:0] shadow_keys [kvt_pkg::MAX_ENTRIES];
    logic [63:0] shadow_vals [kvt_pkg::MAX_ENTRIES];
    int          shadow_count = 0;
    logic [63:0] key_pool [POOL_SIZE];

    t_kv_result  due_results [$];
    int          error_count  = 0;
    int          results_seen = 0;
    int          cycle_count  = 0;
    int          burst_left   = 0;

    t_kv_row directed_rows [NUM_ROWS] = '{
        '{kvt_pkg::OP_GET, 64'h0,    64'h0, 1'b1, '{64'h0, kvt_pkg::ST_MISS,     7'd0}},
        '{kvt_pkg::OP_SET, 64'h5,    64'h0, 1'b1, '{64'h0, kvt_pkg::ST_NOOP,     7'd0}},
        '{kvt_pkg::OP_SET, 64'h0,    ONES,  1'b1, '{64'h0, kvt_pkg::ST_INSERTED, 7'd1}},
        '{kvt_pkg::OP_GET, 64'h0,    64'h0, 1'b1, '{ONES,  kvt_pkg::ST_HIT,      7'd1}},
        '{kvt_pkg::OP_GET, MSB,      64'h0, 1'b1, '{64'h0, kvt_pkg::ST_MISS,     7'd1}},
        '{kvt_pkg::OP_SET, ONES,     64'h1, 1'b1, '{64'h0, kvt_pkg::ST_INSERTED, 7'd2}},
        '{kvt_pkg::OP_SET, ONES,     MSB,   1'b1, '{64'h0, kvt_pkg::ST_UPDATED,  7'd2}},
        '{kvt_pkg::OP_SET, 64'h1234, 64'h7, 1'b1, '{64'h0, kvt_pkg::ST_INSERTED, 7'd3}},
        '{kvt_pkg::OP_GET, ONES,     64'h0, 1'b1, '{MSB,   kvt_pkg::ST_HIT,      7'd3}},
        '{kvt_pkg::OP_SET, 64'h0,    64'h0, 1'b1, '{64'h0, kvt_pkg::ST_REMOVED,  7'd2}},
        '{kvt_pkg::OP_GET, 64'h1234, 64'h0, 1'b0, '0},
        '{kvt_pkg::OP_GET, ONES,     64'h0, 1'b0, '0},
        '{kvt_pkg::OP_GET, 64'h0,    64'h0, 1'b0, '0},
        '{kvt_pkg::OP_SET, 64'h0,    64'h5555_5555_5555_5555, 1'b0, '0},
        '{kvt_pkg::OP_SET, 64'h1234, 64'h0, 1'b0, '0},
        '{kvt_pkg::OP_GET, 64'h0,    64'h0, 1'b0, '0},
        '{kvt_pkg::OP_SET, ONES,     64'h0, 1'b0, '0},
        '{kvt_pkg::OP_SET, 64'h0,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
        '{kvt_pkg::OP_GET, 64'h0,    ONES,  1'b0, '0},
        '{kvt_pkg::OP_SET, 64'h0,    64'h0, 1'b0, '0},
        '{kvt_pkg::OP_SET, 64'h0,    64'h0, 1'b1, '{64'h0, kvt_pkg::ST_NOOP,     7'd0}}
    };

    compacting_key_value_table_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_lookup_key  (i_lookup_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_kv_result apply_table_op(input logic op, input logic [63:0] key,
                                                  input logic [63:0] val);
        t_kv_result res;
        int         pos;
        res = '0;
        pos = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_keys[i] == key) begin
                pos = i;
            end
        end
        if (op == kvt_pkg::OP_GET) begin
            if (pos >= 0) begin
                res.rd     = shadow_vals[pos];
                res.status = kvt_pkg::ST_HIT;
            end else begin
                res.status = kvt_pkg::ST_MISS;
            end
        end else if (pos >= 0) begin
            if (val == '0) begin
                for (int i = pos + 1; i < shadow_count; i++) begin
                    shadow_keys[i-1] = shadow_keys[i];
                    shadow_vals[i-1] = shadow_vals[i];
                end
                shadow_count--;
                res.status = kvt_pkg::ST_REMOVED;
            end else begin
                shadow_vals[pos] = val;
                res.status       = kvt_pkg::ST_UPDATED;
            end
        end else if (val == '0) begin
            res.status = kvt_pkg::ST_NOOP;
        end else if (shadow_count >= kvt_pkg::MAX_ENTRIES) begin
            res.status = kvt_pkg::ST_FULL;
        end else begin
            shadow_keys[shadow_count] = key;
            shadow_vals[shadow_count] = val;
            shadow_count++;
            res.status = kvt_pkg::ST_INSERTED;
        end
        res.count = 7'(shadow_count);
        return res;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Hold the beat until accepted, then queue its expected result.
    task automatic drive_beat(input logic op, input logic [63:0] key, input logic [63:0] val,
                              input logic checked, input t_kv_result want);
        t_kv_result pred;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_lookup_key  <= key;
        i_write_value <= val;
        do @(posedge i_clk); while (!o_ready);
        pred = apply_table_op(op, key, val);
        due_results.push_back(checked ? want : pred);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic pick_random_beat(input t_traffic_phase phase, output logic op,
                                    output logic [63:0] key, output logic [63:0] val);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            op  = 1'($urandom_range(0, 1));
            key = rand_word();
            val = ($urandom_range(0, 1) == 0) ? '0 : rand_word();
            return;
        end
        case (phase)
            PH_GROW: begin
                op  = ($urandom_range(0, 99) < 85) ? kvt_pkg::OP_SET : kvt_pkg::OP_GET;
                val = ($urandom_range(0, 99) < 92) ? rand_word() : '0;
            end
            PH_SHRINK: begin
                op  = ($urandom_range(0, 99) < 75) ? kvt_pkg::OP_SET : kvt_pkg::OP_GET;
                val = ($urandom_range(0, 99) < 70) ? '0 : rand_word();
            end
            default: begin
                op  = ($urandom_range(0, 1) == 0) ? kvt_pkg::OP_SET : kvt_pkg::OP_GET;
                val = ($urandom_range(0, 99) < 30) ? '0 : rand_word();
            end
        endcase
        if (val == '0 && phase == PH_GROW && op == kvt_pkg::OP_SET &&
            $urandom_range(0, 1) == 0) begin
            val = 64'h1;
        end
        roll = $urandom_range(0, 99);
        if (phase == PH_GROW && roll < 40) begin
            key = rand_word();
        end else if (shadow_count > 0 && roll < 70) begin
            key = shadow_keys[$urandom_range(0, shadow_count - 1)];
        end else begin
            key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
    endtask

    initial begin
        logic           op;
        logic [63:0]    key;
        logic [63:0]    val;
        t_traffic_phase plan [4];
        int             plan_len [4];
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = rand_word();
        end
        key_pool[0] = '0;
        key_pool[1] = ONES;
        plan     = '{PH_GROW, PH_MIX, PH_SHRINK, PH_GROW};
        plan_len = '{150, 90, 130, 80};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            drive_beat(directed_rows[r].op, directed_rows[r].key, directed_rows[r].val,
                       directed_rows[r].checked, directed_rows[r].want);
        end
        for (int p = 0; p < 4; p++) begin
            for (int n = 0; n < plan_len[p]; n++) begin
                pick_random_beat(plan[p], op, key, val);
                drive_beat(op, key, val, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && due_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: stall pattern in modes, plus one long hold-off to back up the input.
    int  rx_mode        = 0;
    int  rx_mode_left   = 0;
    int  rx_hold_left   = 0;
    bit  rx_hold_done   = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (!rx_hold_done && results_seen >= 40) begin
                rx_hold_done = 1'b1;
                rx_hold_left = 250;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 80);
            end
            rx_mode_left--;
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_kv_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (due_results.size() == 0) begin
                note_error($sformatf("unexpected beat: rd=%h status=%0d count=%0d",
                                     o_read_value, o_status, o_entry_count));
            end else begin
                want = due_results.pop_front();
                if (o_read_value !== want.rd) begin
                    note_error($sformatf("beat %0d read_value: expected %h, got %h",
                                         results_seen, want.rd, o_read_value));
                end
                if (o_status !== want.status) begin
                    note_error($sformatf("beat %0d status: expected %0d, got %0d",
                                         results_seen, want.status, o_status));
                end
                if (o_entry_count !== want.count) begin
                    note_error($sformatf("beat %0d entry_count: expected %0d, got %0d",
                                         results_seen, want.count, o_entry_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/kvt_pkg.sv
rtl/kvt_cell.sv
rtl/compacting_key_value_table_unit.sv
tb/compacting_key_value_table_unit_tb.sv
